// ===== rtl/core/dense_value_numbering_macros.svh =====
// assertion helpers used by the checker of this block
`ifndef DENSE_VALUE_NUMBERING_MACROS_SVH
`define DENSE_VALUE_NUMBERING_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DVN_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DVN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/dvn_pkg.sv =====
// ----------------------------------------------------------------------------
// dvn_pkg
// Sizes, command codes and word types of the dense value numbering block.
// ----------------------------------------------------------------------------
`default_nettype none

package dvn_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int SPAN       = 4096;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int TB_AW = $clog2(SPAN);

  // fixed field widths of the words on the ports
  localparam int CMD_W      = 2;
  localparam int IN_VALUE_W = 32;
  localparam int IN_INDEX_W = 10;
  localparam int OUT_CNT_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [IN_VALUE_W-1:0] value;
    logic [IN_INDEX_W-1:0] item_index;
  } in_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] rank;
    logic [OUT_CNT_W-1:0] distinct_count;
    logic [OUT_CNT_W-1:0] item_count;
    logic                 span_error;
    logic                 overflow;
    logic                 bad_index;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/dvn_ram.sv =====
// ----------------------------------------------------------------------------
// dvn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dvn_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/dense_value_numbering.sv =====
// ----------------------------------------------------------------------------
// dense_value_numbering
// Renumbers a loaded set of ids to dense 1-based ranks through a presence
// table that is turned into a running prefix sum.
// ----------------------------------------------------------------------------
// A load is accepted back to back and gives no result word. A read holds
// the input through the acceptance, one value store read, one rank table
// read and the output register; a read refused for a bad index or a span
// error goes from acceptance straight to the output register. A finish
// walks the rank table memory three times through its single write port:
// a clear sweep over all SPAN entries, a mark pass over every loaded value
// and a prefix sum pass over all SPAN entries; an empty set or a too wide
// span goes straight to the output register. A result word stalled at the
// output holds the next result back until it leaves. No clearing pass runs
// after reset: the table is cleared by every finish that builds it and read
// only after one. in_stall is high while a command is at work and during
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_value_numbering (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dvn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dvn_pkg::out_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MARK,
    ST_MARK_LAST,
    ST_PSUM,
    ST_PSUM_LAST,
    ST_RD_V,
    ST_RD_T,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic [dvn_pkg::CNT_W-1:0]      count_r;
  logic [dvn_pkg::VALUE_BITS-1:0] min_r;
  logic [dvn_pkg::VALUE_BITS-1:0] max_r;
  logic                           finished_r;
  logic                           dropped_r;
  logic                           span_bad_r;
  logic [dvn_pkg::CNT_W-1:0]      unique_r;
  logic [dvn_pkg::TB_AW-1:0]      k_r;
  logic [dvn_pkg::TB_AW-1:0]      kw_r;
  logic [dvn_pkg::IDX_W-1:0]      i_r;
  logic                           mark_pend_r;
  logic                           psum_pend_r;
  logic [dvn_pkg::CNT_W-1:0]      run_r;
  logic [dvn_pkg::CNT_W-1:0]      rank_r;
  logic                           bad_r;
  logic                           out_valid_r;
  dvn_pkg::out_t                  out_r;

  logic                           accept;
  logic [dvn_pkg::CNT_W-1:0]      base_cnt;
  logic [dvn_pkg::VALUE_BITS-1:0] base_min;
  logic [dvn_pkg::VALUE_BITS-1:0] base_max;
  logic                           base_drop;
  logic [dvn_pkg::VALUE_BITS-1:0] v_in;
  logic [dvn_pkg::VALUE_BITS-1:0] diff;
  logic                           span_wide;
  logic                           room;
  logic                           bad_rd;
  logic [dvn_pkg::VALUE_BITS-1:0] off_full;
  logic [dvn_pkg::TB_AW-1:0]      off;
  logic [dvn_pkg::CNT_W-1:0]      run_sum;

  logic                           vs_we;
  logic [dvn_pkg::IDX_W-1:0]      vs_waddr;
  logic [dvn_pkg::IDX_W-1:0]      vs_raddr;
  logic [dvn_pkg::VALUE_BITS-1:0] vs_rdata;

  logic                           tb_we;
  logic [dvn_pkg::TB_AW-1:0]      tb_waddr;
  logic [dvn_pkg::CNT_W-1:0]      tb_wdata;
  logic [dvn_pkg::TB_AW-1:0]      tb_raddr;
  logic [dvn_pkg::CNT_W-1:0]      tb_rdata;

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a load after a finish starts from an empty set
  assign base_cnt  = finished_r ? '0 : count_r;
  assign base_min  = finished_r ? '1 : min_r;
  assign base_max  = finished_r ? '0 : max_r;
  assign base_drop = finished_r ? 1'b0 : dropped_r;
  assign room      = (32'(base_cnt) < dvn_pkg::MAX_ITEMS);

  assign v_in      = dvn_pkg::VALUE_BITS'(in_data.value);
  assign diff      = max_r - min_r;
  assign span_wide = (64'(diff) >= 64'(dvn_pkg::SPAN));
  assign bad_rd    = !finished_r || (32'(in_data.item_index) >= 32'(count_r));

  assign off_full  = vs_rdata - min_r;
  assign off       = dvn_pkg::TB_AW'(off_full);
  assign run_sum   = run_r + tb_rdata;

  always_comb begin
    vs_we    = accept && (in_data.cmd == dvn_pkg::CMD_LOAD) && room;
    vs_waddr = dvn_pkg::IDX_W'(base_cnt);
    vs_raddr = (state_r == ST_MARK) ? i_r : dvn_pkg::IDX_W'(in_data.item_index);
    tb_raddr = (state_r == ST_RD_V) ? off : k_r;
    tb_we    = 1'b0;
    tb_waddr = k_r;
    tb_wdata = '0;
    if (state_r == ST_CLEAR) begin
      tb_we = 1'b1;
    end else if (mark_pend_r) begin
      // presence mark for the value read in the previous cycle
      tb_we    = 1'b1;
      tb_waddr = off;
      tb_wdata = dvn_pkg::CNT_W'(1);
    end else if (psum_pend_r) begin
      tb_we    = 1'b1;
      tb_waddr = kw_r;
      tb_wdata = run_sum;
    end
  end

  dvn_ram #(
    .DEPTH(dvn_pkg::MAX_ITEMS),
    .WIDTH(dvn_pkg::VALUE_BITS)
  ) u_value_store (
    .clk  (clk),
    .we   (vs_we),
    .waddr(vs_waddr),
    .wdata(v_in),
    .raddr(vs_raddr),
    .rdata(vs_rdata)
  );

  dvn_ram #(
    .DEPTH(dvn_pkg::SPAN),
    .WIDTH(dvn_pkg::CNT_W)
  ) u_rank_table (
    .clk  (clk),
    .we   (tb_we),
    .waddr(tb_waddr),
    .wdata(tb_wdata),
    .raddr(tb_raddr),
    .rdata(tb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      finished_r  <= 1'b0;
      dropped_r   <= 1'b0;
      span_bad_r  <= 1'b0;
      unique_r    <= '0;
      mark_pend_r <= 1'b0;
      psum_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mark_pend_r <= (state_r == ST_MARK);
      psum_pend_r <= (state_r == ST_PSUM);
      kw_r        <= k_r;
      if (psum_pend_r) begin
        run_r <= run_sum;
      end
      if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.cmd)
              dvn_pkg::CMD_LOAD: begin
                finished_r <= 1'b0;
                if (finished_r) begin
                  span_bad_r <= 1'b0;
                  unique_r   <= '0;
                end
                if (room) begin
                  count_r   <= base_cnt + dvn_pkg::CNT_W'(1);
                  min_r     <= (v_in < base_min) ? v_in : base_min;
                  max_r     <= (v_in > base_max) ? v_in : base_max;
                  dropped_r <= base_drop;
                end else begin
                  count_r   <= base_cnt;
                  min_r     <= base_min;
                  max_r     <= base_max;
                  dropped_r <= 1'b1;
                end
              end
              dvn_pkg::CMD_FINISH: begin
                finished_r <= 1'b1;
                span_bad_r <= 1'b0;
                unique_r   <= '0;
                rank_r     <= '0;
                bad_r      <= 1'b0;
                k_r        <= '0;
                run_r      <= '0;
                if (count_r == '0) begin
                  state_r <= ST_EMIT;
                end else if (span_wide) begin
                  span_bad_r <= 1'b1;
                  state_r    <= ST_EMIT;
                end else begin
                  state_r <= ST_CLEAR;
                end
              end
              dvn_pkg::CMD_READ: begin
                rank_r <= '0;
                bad_r  <= bad_rd;
                if (bad_rd || span_bad_r) begin
                  state_r <= ST_EMIT;
                end else begin
                  state_r <= ST_RD_V;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (k_r == dvn_pkg::TB_AW'(dvn_pkg::SPAN - 1)) begin
            k_r     <= '0;
            i_r     <= '0;
            state_r <= ST_MARK;
          end else begin
            k_r <= k_r + dvn_pkg::TB_AW'(1);
          end
        end
        ST_MARK: begin
          i_r <= i_r + dvn_pkg::IDX_W'(1);
          if (32'(i_r) == 32'(count_r) - 32'd1) begin
            state_r <= ST_MARK_LAST;
          end
        end
        ST_MARK_LAST: begin
          k_r     <= '0;
          state_r <= ST_PSUM;
        end
        ST_PSUM: begin
          if (k_r == dvn_pkg::TB_AW'(dvn_pkg::SPAN - 1)) begin
            state_r <= ST_PSUM_LAST;
          end else begin
            k_r <= k_r + dvn_pkg::TB_AW'(1);
          end
        end
        ST_PSUM_LAST: begin
          // the full running sum equals the entry at max - min
          unique_r <= run_sum;
          state_r  <= ST_EMIT;
        end
        ST_RD_V: begin
          state_r <= ST_RD_T;
        end
        ST_RD_T: begin
          rank_r  <= tb_rdata;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_r.rank           <= dvn_pkg::OUT_CNT_W'(rank_r);
            out_r.distinct_count <= (finished_r && !span_bad_r) ?
                                    dvn_pkg::OUT_CNT_W'(unique_r) : '0;
            out_r.item_count     <= dvn_pkg::OUT_CNT_W'(count_r);
            out_r.span_error     <= span_bad_r;
            out_r.overflow       <= dropped_r;
            out_r.bad_index      <= bad_r;
            state_r              <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dvn_checker.sv =====
// ----------------------------------------------------------------------------
// dvn_checker
// Port-level checks of the dense value numbering block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dense_value_numbering_macros.svh"

module dvn_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire dvn_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire dvn_pkg::out_t out_data
);

  logic in_take;
  logic long_cmd;
  logic out_wait;
  logic out_bad;
  logic out_wide;
  logic rank_zero;
  logic cnt_zero;
  logic bounds_ok;

  assign in_take   = in_valid && !in_stall;
  assign long_cmd  = (in_data.cmd == dvn_pkg::CMD_FINISH) ||
                     (in_data.cmd == dvn_pkg::CMD_READ);
  assign out_wait  = out_valid && out_stall;
  assign out_bad   = out_valid && out_data.bad_index;
  assign out_wide  = out_valid && out_data.span_error;
  assign rank_zero = (out_data.rank == '0);
  assign cnt_zero  = (out_data.distinct_count == '0);
  assign bounds_ok = (out_data.rank <= out_data.distinct_count) &&
                     (out_data.distinct_count <= out_data.item_count);

  // a stalled result word holds
  `DVN_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "stalled word changed")

  // finish and read occupy the block for at least the next cycle
  `DVN_ASSERT_NEXT(a_busy_after_cmd, in_take && long_cmd, in_stall, "busy cycle skipped")

  `DVN_ASSERT_NOW(a_bad_rank_zero, out_bad, rank_zero, "bad index with nonzero rank")

  `DVN_ASSERT_NOW(a_span_zero, out_wide, rank_zero && cnt_zero, "span error with nonzero rank")

  `DVN_ASSERT_NOW(a_rank_bound, out_valid, bounds_ok, "rank or count out of order")

endmodule

bind dense_value_numbering dvn_checker u_dvn_checker (.*);

`default_nettype wire
